/* sv/msd_pkg.sv */
// ============================================================================
// msd_pkg: shared types and constants for the message stream deframer
// Result word layout and header geometry.
// ============================================================================
package msd_pkg;

    // Header: group, code, length high byte, length low byte
    localparam int unsigned HEADER_BYTES = 4;
    localparam int unsigned POS_W        = 3;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned LEN_W        = 16;

    // Header positions
    localparam logic [POS_W-1:0] POS_GROUP   = 3'd0;
    localparam logic [POS_W-1:0] POS_CODE    = 3'd1;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 3'd2;
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(HEADER_BYTES);

    typedef struct packed {
        logic [BYTE_W-1:0] group;
        logic [BYTE_W-1:0] code;
        logic [LEN_W-1:0]  msg_length;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  byte_index;
        logic              has_byte;
        logic              last;
    } t_msg;

endpackage

/* sv/msd_if.sv */
// ============================================================================
// msd_if: valid/ready channels of the message stream deframer
// Raw byte channel in, tagged result channel out.
// ============================================================================
interface msd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [msd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface msd_msg_if;
    logic          valid;
    logic          ready;
    msd_pkg::t_msg msg;

    modport source (output valid, output msg, input ready);
    modport sink   (input valid, input msg, output ready);
endinterface

/* sv/msd_parser.sv */
// ============================================================================
// msd_parser: header tracking and result register
// Updates the header/payload state for one byte and registers the result.
// ============================================================================
module msd_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [msd_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                       i_out_ready,
    output logic                       o_take,
    output logic                       o_out_valid,
    output msd_pkg::t_msg              o_out_msg
);

    logic [msd_pkg::POS_W-1:0]  r_pos,    n_pos;
    logic [msd_pkg::BYTE_W-1:0] r_group,  n_group;
    logic [msd_pkg::BYTE_W-1:0] r_code,   n_code;
    logic [msd_pkg::LEN_W-1:0]  r_len,    n_len;
    logic [msd_pkg::LEN_W-1:0]  r_count,  n_count;
    logic                       r_out_valid;
    msd_pkg::t_msg              r_out_msg;
    msd_pkg::t_msg              n_msg;
    logic                       n_emit;
    logic                       advance;
    logic [msd_pkg::LEN_W:0]    next_count;

    // result register free, or being drained this cycle
    assign advance    = !r_out_valid || i_out_ready;
    assign o_take     = i_in_valid && advance;
    assign next_count = {1'b0, r_count} + 1'b1;

    always_comb begin
        n_pos   = r_pos;
        n_group = r_group;
        n_code  = r_code;
        n_len   = r_len;
        n_count = r_count;
        n_emit  = 1'b0;
        n_msg   = '0;
        if (r_pos < msd_pkg::POS_PAYLOAD) begin
            case (r_pos)
                msd_pkg::POS_GROUP:  n_group = i_in_byte;
                msd_pkg::POS_CODE:   n_code  = i_in_byte;
                msd_pkg::POS_LEN_HI: n_len   = {i_in_byte, msd_pkg::BYTE_W'(0)};
                default:             n_len   = {r_len[msd_pkg::LEN_W-1:msd_pkg::BYTE_W],
                                                i_in_byte};
            endcase
            n_pos = r_pos + 1'b1;
            if (n_pos == msd_pkg::POS_PAYLOAD) begin
                n_count = '0;
                if (n_len == '0) begin
                    // empty message: one marker result, back to header
                    n_emit             = 1'b1;
                    n_msg.group        = n_group;
                    n_msg.code         = n_code;
                    n_msg.last         = 1'b1;
                    n_pos              = msd_pkg::POS_GROUP;
                end
            end
        end else begin
            n_emit               = 1'b1;
            n_msg.group          = r_group;
            n_msg.code           = r_code;
            n_msg.msg_length     = r_len;
            n_msg.payload_byte   = i_in_byte;
            n_msg.byte_index     = r_count;
            n_msg.has_byte       = 1'b1;
            n_msg.last           = (next_count >= {1'b0, r_len});
            n_count              = next_count[msd_pkg::LEN_W-1:0];
            if (n_msg.last) begin
                n_pos   = msd_pkg::POS_GROUP;
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= msd_pkg::POS_GROUP;
            r_group     <= '0;
            r_code      <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_pos   <= n_pos;
                r_group <= n_group;
                r_code  <= n_code;
                r_len   <= n_len;
                r_count <= n_count;
            end
            if (advance) begin
                r_out_valid <= o_take && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_msg <= n_msg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_msg   = r_out_msg;

endmodule

/* sv/message_stream_deframer.sv */
// ============================================================================
// message_stream_deframer: length-prefixed message splitter, one byte/cycle unless stalled
// Path: byte accept, input register, result register, then result accept.
//   A stalled output holds words in both registers.
// Throughput: 1 byte per cycle unless the output stalls; header bytes give
//   no result, except the last header byte of an empty message: one marker.
// Reset: synchronous active-low; clears both stages and the header state.
// ============================================================================
module message_stream_deframer (
    input  logic     i_clk,
    input  logic     i_rst_n,
    msd_byte_if.sink i_byte,
    msd_msg_if.source o_msg
);

    // Input register stage. It refills whenever its byte moves on into the
    // parser, so a full result register only stalls the input once both
    // stages hold a word.
    logic                       r_in_valid;
    logic [msd_pkg::BYTE_W-1:0] r_in_byte;
    logic                       take;

    assign i_byte.ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.data_byte;
        end
    end

    // Parser: header position, held header fields, payload count, and the
    // result register that drives the output channel.
    msd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_in_valid),
        .i_in_byte   (r_in_byte),
        .i_out_ready (o_msg.ready),
        .o_take      (take),
        .o_out_valid (o_msg.valid),
        .o_out_msg   (o_msg.msg)
    );

endmodule

/* sv/msd_checker.sv */
// ============================================================================
// msd_checker: port-level checks for the message stream deframer
// Watches the output channel for stalls, tagging consistency and reset.
// ============================================================================
module msd_port_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input msd_pkg::t_msg i_out_msg
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_msg))
        else $error("result word changed while stalled");

    // empty-message marker carries nothing but group/code and last
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_msg.has_byte |->
            i_out_msg.last && i_out_msg.msg_length == '0 &&
            i_out_msg.byte_index == '0 && i_out_msg.payload_byte == '0)
        else $error("bad empty-message marker");

    // payload byte index stays inside the payload; last only on final byte
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_msg.has_byte |->
            i_out_msg.byte_index < i_out_msg.msg_length &&
            (i_out_msg.last == ({1'b0, i_out_msg.byte_index} + 17'd1 ==
                                {1'b0, i_out_msg.msg_length})))
        else $error("byte index or last flag inconsistent with length");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind message_stream_deframer msd_port_checker u_msd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_msg.valid),
    .i_out_ready (o_msg.ready),
    .i_out_msg   (o_msg.msg)
);
